>>> rtl/core/cglf_pkg.sv
// shared constants, command codes, state codes and divider handshake types
package cglf_pkg;

  // curve geometry
  localparam int NUM_POINTS   = 1024;
  localparam int NUM_CHANNELS = 3;

  // field widths on the stream ports
  localparam int CMD_W       = 2;
  localparam int CH_W        = 2;
  localparam int IDX_W       = 10;
  localparam int DATA_W      = 32;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 32;

  // storage addressing: {channel, position}
  localparam int POS_W     = $clog2(NUM_POINTS);
  localparam int CHS_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W    = CHS_W + POS_W;
  localparam int MEM_DEPTH = NUM_CHANNELS * (2 ** POS_W);

  // wide enough to compare an index against the curve length
  localparam int RANGE_W = 17;

  // ramp arithmetic
  localparam int DIFF_W  = DATA_W + 1;
  localparam int SLOPE_W = DATA_W + 1;
  localparam int ACC_W   = DATA_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_ANCHOR = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_RAMP   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dividend;
    logic        [POS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/cglf_ram.sv
// generic one-write one-read synchronous memory, registered read data
module cglf_ram #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 2,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/cglf_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module cglf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cglf_pkg::div_req_t req_i,
  output cglf_pkg::div_rsp_t rsp_o
);
  import cglf_pkg::*;

  localparam int CNT_W = $clog2(DIFF_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [POS_W:0]    rem_q, rem_d;
  logic [DIFF_W-1:0] quo_q, quo_d;
  logic [POS_W-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [POS_W:0]    trial;
  logic              fits;

  // one restoring step
  assign trial = {rem_q[POS_W-1:0], quo_q[DIFF_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      neg_d  = req_i.dividend[DIFF_W-1];
      quo_d  = req_i.dividend[DIFF_W-1] ? DIFF_W'(-req_i.dividend) : DIFF_W'(req_i.dividend);
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[DIFF_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // restore the sign of the magnitude quotient
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> rtl/core/curve_gap_linear_fill_unit.sv
// top level: curve store, command handling and gap fill sequencer
//
// Three response curves of 1024 signed Q16.16 samples sit in one
// single-write single-read memory of 3072 words. After reset the block
// runs a clearing pass, one word per cycle, and takes no item until it is
// done. A write goes to the memory when it is taken; a read passes through
// the memory's read register and then the output register, and no new item
// enters while a result waits in that register. A fill walks every channel:
// it visits each position in turn, fetches the first anchor of each channel,
// and for each run of g missing samples between two anchors runs the 33-step
// slope divider and then writes the g ramp samples. s_axis_tready stays low
// throughout a fill.
module curve_gap_linear_fill_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // channel [1:0], index [11:2], sample_value [43:12], zero pad [47:44]
  input  logic [cglf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command [1:0]
  input  logic [cglf_pkg::CMD_W-1:0]     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // read_value [31:0]
  output logic [cglf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);
  import cglf_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CHS_W-1:0]    ch_q, ch_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    anc_pos_q, anc_pos_d;
  logic [DATA_W-1:0]   anc_val_q, anc_val_d;
  logic [DATA_W-1:0]   here_q, here_d;
  logic [POS_W-1:0]    k_q, k_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SLOPE_W-1:0] slope_q, slope_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;
  logic                rd_oob_q, rd_oob_d;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [CH_W-1:0]     in_ch;
  logic [IDX_W-1:0]    in_idx;
  logic [DATA_W-1:0]   in_val;
  logic [RANGE_W-1:0]  idx_ext;
  logic                in_range;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_xfer;

  logic                last_pos;
  logic                last_ch;
  state_e              adv_state;
  logic [POS_W-1:0]    adv_pos;
  logic [CHS_W-1:0]    adv_ch;
  logic [ADDR_W-1:0]   adv_raddr;

  // input fields
  assign in_ch    = s_axis_tdata[1:0];
  assign in_idx   = s_axis_tdata[11:2];
  assign in_val   = s_axis_tdata[43:12];
  assign idx_ext  = {{(RANGE_W - IDX_W){1'b0}}, in_idx};
  assign in_range = ({1'b0, in_ch} < (CH_W + 1)'(NUM_CHANNELS))
                  && (idx_ext < RANGE_W'(NUM_POINTS));
  assign in_addr  = {in_ch[CHS_W-1:0], idx_ext[POS_W-1:0]};

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // step to the next position, or the next channel, or finish the fill
  assign last_pos = pos_q == POS_W'(NUM_POINTS - 1);
  assign last_ch  = ch_q == CHS_W'(NUM_CHANNELS - 1);

  always_comb begin
    adv_pos   = pos_q;
    adv_ch    = ch_q;
    adv_raddr = {ch_q, pos_q};
    adv_state = ST_IDLE;
    if (!last_pos) begin
      adv_pos   = pos_q + 1'b1;
      adv_raddr = {ch_q, adv_pos};
      adv_state = ST_SCAN;
    end else if (!last_ch) begin
      adv_ch    = ch_q + 1'b1;
      adv_raddr = {adv_ch, {POS_W{1'b0}}};
      adv_state = ST_ANCHOR;
    end
  end

  // main sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    anc_pos_d   = anc_pos_q;
    anc_val_d   = anc_val_q;
    here_d      = here_q;
    k_d         = k_q;
    acc_d       = acc_q;
    slope_d     = slope_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    rd_oob_d    = rd_oob_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    div_req.start    = 1'b0;
    div_req.dividend = $signed({mem_rdata[DATA_W-1], mem_rdata})
                     - $signed({anc_val_q[DATA_W-1], anc_val_q});
    div_req.divisor  = pos_q - anc_pos_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (s_axis_tuser)
            CMD_WRITE: begin
              mem_we    = in_range;
              mem_waddr = in_addr;
              mem_wdata = in_val;
            end
            CMD_FILL: begin
              ch_d      = '0;
              mem_raddr = '0;
              state_d   = ST_ANCHOR;
            end
            CMD_READ: begin
              mem_raddr = in_addr;
              rd_oob_d  = !in_range;
              state_d   = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = rd_oob_q ? '0 : mem_rdata;
        state_d     = ST_IDLE;
      end
      ST_ANCHOR: begin
        // position zero is the first anchor whatever its value
        anc_val_d = mem_rdata;
        anc_pos_d = '0;
        pos_d     = POS_W'(1);
        mem_raddr = {ch_q, POS_W'(1)};
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (mem_rdata != '0 && (anc_pos_q + 1'b1) != pos_q) begin
          // gap closed: work out the slope first
          here_d        = mem_rdata;
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          if (mem_rdata != '0) begin
            anc_pos_d = pos_q;
            anc_val_d = mem_rdata;
          end
          pos_d     = adv_pos;
          ch_d      = adv_ch;
          mem_raddr = adv_raddr;
          state_d   = adv_state;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          slope_d = div_rsp.quotient;
          acc_d   = $signed({{2{anc_val_q[DATA_W-1]}}, anc_val_q})
                  + $signed({div_rsp.quotient[SLOPE_W-1], div_rsp.quotient});
          k_d     = anc_pos_q + 1'b1;
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        mem_we    = 1'b1;
        mem_waddr = {ch_q, k_q};
        mem_wdata = acc_q[DATA_W-1:0];
        acc_d     = acc_q + $signed({slope_q[SLOPE_W-1], slope_q});
        k_d       = k_q + 1'b1;
        if ((k_q + 1'b1) == pos_q) begin
          anc_pos_d = pos_q;
          anc_val_d = here_q;
          pos_d     = adv_pos;
          ch_d      = adv_ch;
          mem_raddr = adv_raddr;
          state_d   = adv_state;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ch_q        <= '0;
      pos_q       <= '0;
      anc_pos_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      rd_oob_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ch_q        <= ch_d;
      pos_q       <= pos_d;
      anc_pos_q   <= anc_pos_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      rd_oob_q    <= rd_oob_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    anc_val_q  <= anc_val_d;
    here_q     <= here_d;
    acc_q      <= acc_d;
    slope_q    <= slope_d;
    out_data_q <= out_data_d;
  end

  // curve store
  cglf_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // slope divider
  cglf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

>>> rtl/core/cglf_checker.sv
// port-level checks on the gap fill unit, bound to the top level
module cglf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic [cglf_pkg::CMD_W-1:0]     s_axis_tuser,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [cglf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import cglf_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no item is taken while a result sits stalled in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tready)
    else $error("input taken with a stalled result pending");

  // a read transfer yields its result once it has passed the read state and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ |-> ##2 m_axis_tvalid)
    else $error("read result missing");

  // writes, fills and unused codes never raise a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_READ
      |=> !$rose(m_axis_tvalid))
    else $error("result raised without a read");

endmodule

bind curve_gap_linear_fill_unit cglf_checker u_cglf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

>>> tb/testbench.sv
// testbench for the curve gap fill unit: directed and random command streams
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cglf_pkg::*;

  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // at most 49 fills run; the limit covers them, the clearing pass and
  // the reads and writes with stalls
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int FILLS_PER_PHASE = 16;

  // prediction of the curve store and the queue of expected read values
  class curve_fill_scoreboard;
    bit [DATA_W-1:0] curve_mem [NUM_CHANNELS][NUM_POINTS];
    bit [DATA_W-1:0] read_value_q [$];
    int errors;
    int writes_done;
    int fills_done;
    int ignored_items;
    int reads_checked;

    // walk every channel and replace each run of zeros between anchors by a ramp
    function void fill_curves();
      int anchor_pos;
      bit [DATA_W-1:0] anchor_val;
      bit [DATA_W-1:0] here;
      longint left;
      longint slope;
      longint v;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        anchor_pos = 0;
        anchor_val = curve_mem[c][0];
        for (int p = 1; p < NUM_POINTS; p++) begin
          here = curve_mem[c][p];
          if (here != 0) begin
            if (anchor_pos + 1 < p) begin
              left  = longint'($signed(anchor_val));
              slope = (longint'($signed(here)) - left) / longint'(p - anchor_pos);
              for (int k = anchor_pos + 1; k < p; k++) begin
                v = left + slope * longint'(k - anchor_pos);
                curve_mem[c][k] = v[DATA_W-1:0];
              end
            end
            anchor_pos = p;
            anchor_val = here;
          end
        end
      end
    endfunction

    // note one accepted command transfer
    function void note_command(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                               logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      bit in_range;
      in_range = (ch < NUM_CHANNELS) && (idx < NUM_POINTS);
      if (cmd == CMD_WRITE) begin
        if (in_range) curve_mem[ch][idx] = val;
        writes_done++;
      end else if (cmd == CMD_FILL) begin
        fill_curves();
        fills_done++;
      end else if (cmd == CMD_READ) begin
        read_value_q.insert(read_value_q.size(), in_range ? curve_mem[ch][idx] : '0);
      end else begin
        ignored_items++;
      end
    endfunction

    // compare one result transfer with the oldest expected read
    function void check_read(logic [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (read_value_q.size() == 0) begin
        $error("read_value: no read pending, actual 0x%08h", got);
        errors++;
        return;
      end
      want = read_value_q.pop_front();
      reads_checked++;
      if (got !== want) begin
        $error("read_value mismatch: expected 0x%08h, actual 0x%08h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  curve_fill_scoreboard curve_sb = new();

  curve_gap_linear_fill_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) curve_sb.check_read(m_axis_tdata);
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // offer one command and wait for its transfer
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, val, idx, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    curve_sb.note_command(cmd, ch, idx, val);
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    return ($urandom_range(0, 9) == 0) ? CH_W'(3) : CH_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return IDX_W'(NUM_POINTS - 1);
      default: return IDX_W'($urandom_range(0, NUM_POINTS - 1));
    endcase
  endfunction

  // zeros punch holes, small values give ramps that round to zero
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return DATA_W'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // write a few anchors, usually fill, then read back
  task automatic run_fill_sessions(input int n_items);
    int sent;
    int fills;
    sent = 0;
    fills = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(CMD_UNUSED, CH_W'($urandom), IDX_W'($urandom), $urandom);
        end
        send_item(CMD_WRITE, pick_channel(), pick_index(), pick_value());
        sent++;
      end
      if (fills < FILLS_PER_PHASE && $urandom_range(0, 3) != 0) begin
        send_item(CMD_FILL, CH_W'($urandom), IDX_W'($urandom), $urandom);
        fills++;
        sent++;
      end
      repeat ($urandom_range(2, 12)) begin
        send_item(CMD_READ, pick_channel(), pick_index(), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_WRITE;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cleared store, extreme values, out-of-range channel,
    // unused command, ramps rounding to zero, zero first anchor, trailing zeros
    send_item(CMD_READ,   2'd0, 10'd0,    32'h0);
    send_item(CMD_WRITE,  2'd0, 10'd1023, 32'h7FFF_FFFF);
    send_item(CMD_WRITE,  2'd0, 10'd10,   32'h8000_0000);
    send_item(CMD_WRITE,  2'd1, 10'd0,    32'hFFFF_FFFC);
    send_item(CMD_WRITE,  2'd1, 10'd4,    32'h0000_0004);
    send_item(CMD_WRITE,  2'd2, 10'd5,    32'h0000_0001);
    send_item(CMD_WRITE,  2'd2, 10'd9,    32'hFFFF_FFFF);
    send_item(CMD_WRITE,  2'd3, 10'd7,    32'h0000_007B);
    send_item(CMD_UNUSED, 2'd3, 10'd1023, 32'hFFFF_FFFF);
    send_item(CMD_FILL,   2'd0, 10'd0,    32'h0);
    send_item(CMD_READ,   2'd0, 10'd5,    32'h0);
    send_item(CMD_READ,   2'd0, 10'd500,  32'h0);
    send_item(CMD_READ,   2'd0, 10'd1023, 32'h0);
    send_item(CMD_READ,   2'd1, 10'd2,    32'h0);
    send_item(CMD_READ,   2'd1, 10'd3,    32'h0);
    send_item(CMD_READ,   2'd2, 10'd3,    32'h0);
    send_item(CMD_READ,   2'd2, 10'd7,    32'h0);
    send_item(CMD_READ,   2'd3, 10'd7,    32'h0);
    send_item(CMD_READ,   2'd1, 10'd600,  32'h0);

    // random sessions under three idling patterns
    src_idle_pct  = 7;
    sink_idle_pct = 65;
    run_fill_sessions(200);
    src_idle_pct  = 65;
    sink_idle_pct = 7;
    run_fill_sessions(200);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_fill_sessions(200);
    s_axis_tvalid <= 1'b0;

    // drain outstanding reads
    while (curve_sb.read_value_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d writes, %0d fills and %0d ignored commands",
             curve_sb.writes_done, curve_sb.fills_done, curve_sb.ignored_items);
    $display("%0d read results compared, %0d mismatches",
             curve_sb.reads_checked, curve_sb.errors);
    if (curve_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cglf_pkg.sv
rtl/core/cglf_ram.sv
rtl/core/cglf_div.sv
rtl/core/curve_gap_linear_fill_unit.sv
rtl/core/cglf_checker.sv
tb/testbench.sv
